// ===== rtl/stdq_pkg.sv =====
// ---------------------------------------------------------------------------
// stdq_pkg
// Shared types, sizes and helpers for the sorted timer deadline queue.
// ---------------------------------------------------------------------------
package stdq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TIME_BITS   = 32;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W       = CNT_W + 1;
  localparam int PID_W       = 8;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [PTR_W-1:0]     ptr_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [PID_W-1:0]     pid_t;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic  en;
    ptr_t  addr;
    time_t tm;
    pid_t  pid;
  } stdq_wr_t;

  typedef struct packed {
    logic en;
    ptr_t addr;
  } stdq_rd_t;

  // physical slot of a logical offset from the ring base
  function automatic ptr_t wrap_add(ptr_t b, cnt_t off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(b) + SUM_W'(off);
    if (s >= SUM_W'(QUEUE_DEPTH)) begin
      s = s - SUM_W'(QUEUE_DEPTH);
    end
    return PTR_W'(s);
  endfunction

endpackage

// ===== rtl/stdq_store.sv =====
// ---------------------------------------------------------------------------
// stdq_store
// Entry memory of the queue: one write port, one registered read port.
// ---------------------------------------------------------------------------
module stdq_store (
  input  logic             clk,
  input  stdq_pkg::stdq_wr_t wr,
  input  stdq_pkg::stdq_rd_t rd,
  output stdq_pkg::time_t  rd_time,
  output stdq_pkg::pid_t   rd_pid
);
  import stdq_pkg::*;

  time_t mem_time [QUEUE_DEPTH];
  pid_t  mem_pid  [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_time[wr.addr] <= wr.tm;
      mem_pid[wr.addr]  <= wr.pid;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_time <= mem_time[rd.addr];
      rd_pid  <= mem_pid[rd.addr];
    end
  end

endmodule

// ===== rtl/sorted_timer_deadline_queue_top.sv =====
// ---------------------------------------------------------------------------
// sorted_timer_deadline_queue_top
// Timer queue sorted by wake-up time, kept in a ring memory and updated by
// a sequencer around one shared magnitude comparator.
// ---------------------------------------------------------------------------
// sequence: enqueue into an empty or full queue answers from S_START; otherwise
//   S_SCAN shifts each later entry up one slot (one memory read and one compare
//   per step), then writes the new entry; dequeue loads a new head in S_HEAD
// flow: one request in flight, its reply held in an output register until taken
// reset: synchronous, clears count, ring base and handshake state; the entry
//   memory is not cleared
module sorted_timer_deadline_queue_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                operation,
  input  logic [7:0]          process_id,
  input  logic [31:0]         end_time,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                restart_timer,
  output logic [7:0]          woken_process,
  output logic [4:0]          entry_count,
  output logic [31:0]         head_time,
  output stdq_pkg::status_t   status
);
  import stdq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_PLACE,
    S_HEAD
  } state_t;

  state_t   state;
  op_t      req_op;
  pid_t     req_pid;
  time_t    req_time;
  cnt_t     occ;
  ptr_t     base;
  cnt_t     idx;
  time_t    head_tm;
  pid_t     head_pid;
  logic     restart;

  stdq_wr_t wr;
  stdq_rd_t rd;
  time_t    rd_time;
  pid_t     rd_pid;
  time_t    cmp_opnd;
  logic     cmp_gt;
  logic     is_full;

  stdq_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_time (rd_time),
    .rd_pid  (rd_pid)
  );

  // shared comparator
  assign cmp_opnd = (state == S_START) ? head_tm : rd_time;
  assign cmp_gt   = cmp_opnd > req_time;
  assign is_full  = occ == CNT_W'(QUEUE_DEPTH);
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);

  always_comb begin
    wr = '0;
    rd = '0;
    unique case (state)
      S_START: begin
        if (req_op == OP_ENQ) begin
          if (occ == '0) begin
            wr.en   = 1'b1;
            wr.addr = base;
            wr.tm   = req_time;
            wr.pid  = req_pid;
          end else if (!is_full) begin
            rd.en   = 1'b1;
            rd.addr = wrap_add(base, CNT_W'(occ - CNT_W'(1)));
          end
        end else if (occ > CNT_W'(1)) begin
          rd.en   = 1'b1;
          rd.addr = wrap_add(base, CNT_W'(1));
        end
      end
      S_SCAN: begin
        wr.en   = 1'b1;
        wr.addr = wrap_add(base, idx);
        if (cmp_gt) begin
          wr.tm  = rd_time;
          wr.pid = rd_pid;
          if (idx != CNT_W'(1)) begin
            rd.en   = 1'b1;
            rd.addr = wrap_add(base, CNT_W'(idx - CNT_W'(2)));
          end
        end else begin
          wr.tm  = req_time;
          wr.pid = req_pid;
        end
      end
      S_PLACE: begin
        wr.en   = 1'b1;
        wr.addr = base;
        wr.tm   = req_time;
        wr.pid  = req_pid;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      base      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            req_op   <= op_t'(operation);
            req_pid  <= process_id;
            req_time <= TIME_BITS'(end_time);
            state    <= S_START;
          end
        end
        S_START: begin
          if (req_op == OP_ENQ) begin
            if (is_full) begin
              out_valid     <= 1'b1;
              restart_timer <= 1'b0;
              woken_process <= '0;
              entry_count   <= 5'(occ);
              head_time     <= 32'(head_tm);
              status        <= STAT_FULL;
              state         <= S_IDLE;
            end else if (occ == '0) begin
              occ           <= CNT_W'(1);
              head_tm       <= req_time;
              head_pid      <= req_pid;
              out_valid     <= 1'b1;
              restart_timer <= 1'b1;
              woken_process <= '0;
              entry_count   <= 5'd1;
              head_time     <= 32'(req_time);
              status        <= STAT_OK;
              state         <= S_IDLE;
            end else begin
              restart <= cmp_gt;
              idx     <= occ;
              state   <= S_SCAN;
            end
          end else begin
            if (occ == '0) begin
              out_valid     <= 1'b1;
              restart_timer <= 1'b0;
              woken_process <= '0;
              entry_count   <= '0;
              head_time     <= '0;
              status        <= STAT_EMPTY;
              state         <= S_IDLE;
            end else begin
              woken_process <= head_pid;
              base          <= wrap_add(base, CNT_W'(1));
              occ           <= CNT_W'(occ - CNT_W'(1));
              if (occ == CNT_W'(1)) begin
                out_valid     <= 1'b1;
                restart_timer <= 1'b0;
                entry_count   <= '0;
                head_time     <= '0;
                status        <= STAT_OK;
                state         <= S_IDLE;
              end else begin
                state <= S_HEAD;
              end
            end
          end
        end
        S_SCAN: begin
          if (cmp_gt) begin
            idx <= CNT_W'(idx - CNT_W'(1));
            if (idx == CNT_W'(1)) begin
              state <= S_PLACE;
            end
          end else begin
            occ           <= CNT_W'(occ + CNT_W'(1));
            out_valid     <= 1'b1;
            restart_timer <= restart;
            woken_process <= '0;
            entry_count   <= 5'(occ + CNT_W'(1));
            head_time     <= 32'(head_tm);
            status        <= STAT_OK;
            state         <= S_IDLE;
          end
        end
        S_PLACE: begin
          head_tm       <= req_time;
          head_pid      <= req_pid;
          occ           <= CNT_W'(occ + CNT_W'(1));
          out_valid     <= 1'b1;
          restart_timer <= restart;
          woken_process <= '0;
          entry_count   <= 5'(occ + CNT_W'(1));
          head_time     <= 32'(req_time);
          status        <= STAT_OK;
          state         <= S_IDLE;
        end
        S_HEAD: begin
          head_tm       <= rd_time;
          head_pid      <= rd_pid;
          out_valid     <= 1'b1;
          restart_timer <= 1'b0;
          entry_count   <= 5'(occ);
          head_time     <= 32'(rd_time);
          status        <= STAT_OK;
          state         <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== tb/sv/tb_sorted_timer_deadline_queue_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_sorted_timer_deadline_queue_top
// Self-checking bench for the sorted timer deadline queue. A scoreboard class
// keeps its own sorted copy of the queue and works out the reply word for
// every accepted request word. Replies are compared field by field in order.
// Directed words cover empty and full queues, ties and head changes. Random
// bursts then walk the queue between empty and full under three idling mixes.
// A long receiver hold-off makes the block back up its input.
// ---------------------------------------------------------------------------
module tb_sorted_timer_deadline_queue_top;
  import stdq_pkg::*;

  localparam int CLK_PERIOD  = 12;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 40;
  localparam int HOLD_CYCLES = 150;

  typedef struct {
    logic    restart;
    pid_t    woken;
    cnt_t    count;
    time_t   head;
    status_t stat;
  } reply_t;

  class deadline_scoreboard;
    time_t  slot_time [QUEUE_DEPTH];
    pid_t   slot_pid [QUEUE_DEPTH];
    int     fill;
    reply_t awaited_replies[$];
    int     mismatches;
    int     n_enq, n_deq, n_full, n_empty, n_restart, n_checked;

    function new();
      fill = 0;
      mismatches = 0;
      n_enq = 0;
      n_deq = 0;
      n_full = 0;
      n_empty = 0;
      n_restart = 0;
      n_checked = 0;
    endfunction

    function void predict_reply(op_t op, pid_t pid, time_t tm);
      reply_t r;
      int     pos;
      r.restart = 1'b0;
      r.woken   = '0;
      r.stat    = STAT_OK;
      if (op == OP_ENQ) begin
        n_enq++;
        if (fill >= QUEUE_DEPTH) begin
          r.stat = STAT_FULL;
          n_full++;
        end else begin
          r.restart = (fill == 0) || (tm < slot_time[0]);
          if (r.restart) n_restart++;
          pos = 0;
          while (pos < fill && slot_time[pos] <= tm) pos++;
          for (int i = fill; i > pos; i--) begin
            slot_time[i] = slot_time[i-1];
            slot_pid[i]  = slot_pid[i-1];
          end
          slot_time[pos] = tm;
          slot_pid[pos]  = pid;
          fill++;
        end
      end else begin
        n_deq++;
        if (fill == 0) begin
          r.stat = STAT_EMPTY;
          n_empty++;
        end else begin
          r.woken = slot_pid[0];
          for (int i = 1; i < fill; i++) begin
            slot_time[i-1] = slot_time[i];
            slot_pid[i-1]  = slot_pid[i];
          end
          fill--;
        end
      end
      r.count = cnt_t'(fill);
      r.head  = (fill > 0) ? slot_time[0] : '0;
      awaited_replies.push_back(r);
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h",
               $realtime, what, got, want);
    endtask

    task compare_reply(logic restart, pid_t woken, cnt_t count, time_t head,
                       logic [1:0] stat);
      reply_t r;
      if (awaited_replies.size() == 0) begin
        report_mismatch("unexpected reply word", {62'd0, stat}, 64'd0);
        return;
      end
      r = awaited_replies.pop_front();
      n_checked++;
      if (restart !== r.restart)
        report_mismatch("restart_timer", 64'(restart), 64'(r.restart));
      if (woken !== r.woken)
        report_mismatch("woken_process", 64'(woken), 64'(r.woken));
      if (count !== r.count)
        report_mismatch("entry_count", 64'(count), 64'(r.count));
      if (head !== r.head)
        report_mismatch("head_time", 64'(head), 64'(r.head));
      if (stat !== r.stat)
        report_mismatch("status", 64'(stat), 64'(r.stat));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        operation;
  logic [7:0]  process_id;
  logic [31:0] end_time;
  logic        out_valid;
  logic        out_stall;
  logic        restart_timer;
  logic [7:0]  woken_process;
  logic [4:0]  entry_count;
  logic [31:0] head_time;
  status_t     status;

  deadline_scoreboard deadline_sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  sorted_timer_deadline_queue_top dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .process_id    (process_id),
    .end_time      (end_time),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .restart_timer (restart_timer),
    .woken_process (woken_process),
    .entry_count   (entry_count),
    .head_time     (head_time),
    .status        (status)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // receiver side: random stall, or a counted hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      deadline_sb.compare_reply(restart_timer, woken_process, entry_count, head_time,
                                status);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic time_t pick_time();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return time_t'($urandom_range(0, 15));
      default: return time_t'($urandom);
    endcase
  endfunction

  task automatic send_word(op_t op, pid_t pid, time_t tm);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid   <= 1'b0;
      operation  <= 1'($urandom_range(0, 1));
      process_id <= 8'($urandom_range(0, 255));
      end_time   <= $urandom;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    process_id <= pid;
    end_time   <= tm;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    deadline_sb.predict_reply(op, pid, tm);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (deadline_sb.awaited_replies.size() != 0) @(posedge clk);
  endtask

  task automatic random_bursts(int total);
    int sent;
    int enq_pct;
    int len;
    sent = 0;
    while (sent < total) begin
      case ($urandom_range(0, 4))
        0: enq_pct = 15;
        1: enq_pct = 50;
        2: enq_pct = 85;
        3: enq_pct = 100;
        default: enq_pct = $urandom_range(0, 100);
      endcase
      len = $urandom_range(8, 40);
      for (int i = 0; i < len && sent < total; i++) begin
        if ($urandom_range(0, 99) < enq_pct)
          send_word(OP_ENQ, pid_t'($urandom_range(0, 255)), pick_time());
        else
          send_word(OP_DEQ, pid_t'($urandom_range(0, 255)), time_t'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    operation  = OP_ENQ;
    process_id = '0;
    end_time   = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 35;
    recv_idle_pct = 60;
    // empty dequeue, head replacement, ties, then fill past full
    send_word(OP_DEQ, 8'h00, 32'h0);
    send_word(OP_ENQ, 8'h00, 32'd100);
    send_word(OP_ENQ, 8'hFF, 32'hFFFF_FFFF);
    send_word(OP_ENQ, 8'hAA, 32'd100);
    send_word(OP_ENQ, 8'h55, 32'd99);
    send_word(OP_ENQ, 8'h01, 32'h0);
    send_word(OP_ENQ, 8'h80, 32'h8000_0000);
    for (int i = 0; i < 10; i++)
      send_word(OP_ENQ, pid_t'(i * 23 + 3), time_t'((i % 3) * 7 + 50));
    send_word(OP_ENQ, 8'h7F, 32'h0);
    repeat (3) send_word(OP_DEQ, 8'hFF, 32'hFFFF_FFFF);
    random_bursts(440);
    wait_drained();

    send_idle_pct = 60;
    recv_idle_pct = 35;
    random_bursts(450);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    random_bursts(500);
    wait_drained();

    repeat (DRAIN_WAIT) @(posedge clk);

    $display("run covered %0d enqueues (%0d head restarts, %0d refused when full)",
             deadline_sb.n_enq, deadline_sb.n_restart, deadline_sb.n_full);
    $display("and %0d dequeues (%0d on an empty queue); %0d replies compared",
             deadline_sb.n_deq, deadline_sb.n_empty, deadline_sb.n_checked);
    if (deadline_sb.mismatches == 0 && deadline_sb.awaited_replies.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d replies missing", deadline_sb.mismatches,
               deadline_sb.awaited_replies.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
